FILE: sv/tah_pkg.sv
// Shared constants and types for the Heron triangle area pipeline.
package tah_pkg;

    localparam int DEFAULT_SIDE_BITS = 12;
    localparam int AREA_W = 30;
    localparam int N_W = 2 * AREA_W;
    localparam int ROOT_STAGES = AREA_W;
    localparam int CMP_W = 68;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [CMP_W-1:0] SQ_LIMIT =
        ((CMP_W'(1) << N_W) - (CMP_W'(1) << AREA_W)) / CMP_W'(625);

    typedef struct packed {
        logic [N_W-1:0] rem;
        logic [N_W-1:0] root;
        logic           ok;
        logic           sat;
    } root_t;

endpackage

FILE: sv/tah_prep.sv
// Front end: sorts the sides, checks the triangle, flags saturation and forms 625 times (a+b+c)(b+c-a)(a+c-b)(a+b-c).
module tah_prep
    import tah_pkg::*;
#(
    parameter int SIDE_BITS = DEFAULT_SIDE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SIDE_BITS-1:0] side_a,
    input  logic [SIDE_BITS-1:0] side_b,
    input  logic [SIDE_BITS-1:0] side_c,
    output logic                 out_valid,
    input  logic                 out_ready,
    output root_t                out_data
);

    localparam int SB = SIDE_BITS;
    localparam int SUM_W = SB + 2;
    localparam int P1_W = 2 * SB + 2;
    localparam int P2_W = 3 * SB + 2;
    localparam int P3_W = 4 * SB + 3;
    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   rdy;

    logic [SB-1:0] xs, ys, zs, t0, t1, t2;
    logic [SB-1:0] xa_reg, ya_reg, za_reg;

    logic [SB:0]      sum_yz;
    logic             ok_b_reg;
    logic [SUM_W-1:0] s_b_reg;
    logic [SB-1:0]    f1_b_reg, f2_b_reg;
    logic [SB:0]      f3_b_reg;

    logic            ok_c_reg;
    logic [P1_W-1:0] p1_c_reg;
    logic [SB-1:0]   f2_c_reg;
    logic [SB:0]     f3_c_reg;

    logic            ok_d_reg;
    logic [P2_W-1:0] p2_d_reg;
    logic [SB:0]     f3_d_reg;

    logic            ok_e_reg;
    logic [P3_W-1:0] p3_e_reg;
    logic [CMP_W-1:0] p3_ext;

    logic           ok_f_reg, sat_f_reg;
    logic [N_W-1:0] n_f_reg;
    logic [N_W-1:0] n_next;

    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign v_next = {v_reg[NST-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_comb begin
        xs = side_a;
        ys = side_b;
        zs = side_c;
        if (xs < ys) begin
            t0 = xs; xs = ys; ys = t0;
        end else begin
            t0 = '0;
        end
        if (xs < zs) begin
            t1 = xs; xs = zs; zs = t1;
        end else begin
            t1 = '0;
        end
        if (ys < zs) begin
            t2 = ys; ys = zs; zs = t2;
        end else begin
            t2 = '0;
        end
    end

    assign sum_yz = {1'b0, ya_reg} + {1'b0, za_reg};
    assign p3_ext = CMP_W'(p3_e_reg);
    assign n_next = (p3_ext[N_W-1:0] << 9) + (p3_ext[N_W-1:0] << 6)
                  + (p3_ext[N_W-1:0] << 5) + (p3_ext[N_W-1:0] << 4) + p3_ext[N_W-1:0];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            xa_reg <= xs;
            ya_reg <= ys;
            za_reg <= zs;
        end
        if (rdy[1]) begin
            ok_b_reg <= {1'b0, xa_reg} < sum_yz;
            s_b_reg  <= {2'b0, xa_reg} + {1'b0, sum_yz};
            f1_b_reg <= SB'(sum_yz - {1'b0, xa_reg});
            f2_b_reg <= xa_reg - ya_reg + za_reg;
            f3_b_reg <= {1'b0, xa_reg} + {1'b0, ya_reg} - {1'b0, za_reg};
        end
        if (rdy[2]) begin
            ok_c_reg <= ok_b_reg;
            p1_c_reg <= s_b_reg * f1_b_reg;
            f2_c_reg <= f2_b_reg;
            f3_c_reg <= f3_b_reg;
        end
        if (rdy[3]) begin
            ok_d_reg <= ok_c_reg;
            p2_d_reg <= p1_c_reg * f2_c_reg;
            f3_d_reg <= f3_c_reg;
        end
        if (rdy[4]) begin
            ok_e_reg <= ok_d_reg;
            p3_e_reg <= p2_d_reg * f3_d_reg;
        end
        if (rdy[5]) begin
            ok_f_reg  <= ok_e_reg;
            sat_f_reg <= p3_ext > SQ_LIMIT;
            n_f_reg   <= n_next;
        end
    end

    assign in_ready      = rdy[0];
    assign out_valid     = v_reg[NST-1];
    assign out_data.rem  = n_f_reg;
    assign out_data.root = '0;
    assign out_data.ok   = ok_f_reg;
    assign out_data.sat  = sat_f_reg;

endmodule

FILE: sv/tah_root_cell.sv
// One stage of the square root chain, resolving one bit of the root.
module tah_root_cell
    import tah_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  root_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output root_t out_data
);

    localparam logic [N_W:0] BIT = (N_W + 1)'(1) << (2 * STAGE);

    logic         v_reg;
    root_t        d_reg;
    root_t        d_next;
    logic [N_W:0] trial;

    assign in_ready = !v_reg || out_ready;
    assign trial    = {1'b0, in_data.root} + BIT;

    always_comb begin
        d_next = in_data;
        if ({1'b0, in_data.rem} >= trial) begin
            d_next.rem  = in_data.rem - trial[N_W-1:0];
            d_next.root = (in_data.root >> 1) + BIT[N_W-1:0];
        end else begin
            d_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

FILE: sv/triangle_area_heron.sv
// Top level of the Heron triangle area pipeline with its output register.
// Takes one triangle per clock cycle while m_ready does not hold the output back, and
// returns 100 times its area, rounded half up, through six front-end stages (sort,
// check, three registered multiplies, saturation and the scaling by 625), thirty root
// cells that each settle one bit of the square root, and the rounding output register.
// Every stage holds one beat and moves it on whenever the next stage is free, so the
// block keeps taking beats while a finished result waits at the output, until every
// stage is full. Degenerate and zero-sided triangles give is_valid low and a zero area;
// areas beyond the 30-bit range saturate.
module triangle_area_heron
    import tah_pkg::*;
#(
    parameter int SIDE_BITS = DEFAULT_SIDE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SIDE_BITS-1:0] s_side_a,
    input  logic [SIDE_BITS-1:0] s_side_b,
    input  logic [SIDE_BITS-1:0] s_side_c,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [AREA_W-1:0]    m_area_hundredths,
    output logic                 m_is_valid
);

    logic                 ch_valid [ROOT_STAGES+1];
    logic                 ch_ready [ROOT_STAGES+1];
    root_t                ch_data  [ROOT_STAGES+1];

    logic                 m_valid_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [AREA_W-1:0]    area_next;
    logic                 is_valid_reg;
    logic                 out_load;
    logic                 round_up;
    logic [AREA_W:0]      rounded;
    root_t                fin;

    tah_prep #(
        .SIDE_BITS(SIDE_BITS)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .side_a   (s_side_a),
        .side_b   (s_side_b),
        .side_c   (s_side_c),
        .out_valid(ch_valid[0]),
        .out_ready(ch_ready[0]),
        .out_data (ch_data[0])
    );

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
        tah_root_cell #(
            .STAGE(ROOT_STAGES - 1 - k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (ch_valid[k]),
            .in_ready (ch_ready[k]),
            .in_data  (ch_data[k]),
            .out_valid(ch_valid[k+1]),
            .out_ready(ch_ready[k+1]),
            .out_data (ch_data[k+1])
        );
    end

    assign fin      = ch_data[ROOT_STAGES];
    assign out_load = !m_valid_reg || m_ready;
    assign ch_ready[ROOT_STAGES] = out_load;
    assign round_up = fin.rem > fin.root;
    assign rounded  = {1'b0, fin.root[AREA_W-1:0]} + {{AREA_W{1'b0}}, round_up};

    always_comb begin
        if (!fin.ok) begin
            area_next = '0;
        end else if (fin.sat || rounded[AREA_W]) begin
            area_next = AREA_MAX;
        end else begin
            area_next = rounded[AREA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= ch_valid[ROOT_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            area_reg     <= area_next;
            is_valid_reg <= fin.ok;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_area_hundredths = area_reg;
    assign m_is_valid        = is_valid_reg;

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !is_valid_reg) |-> (area_reg == '0))
        else $error("Rejected triangle carries a nonzero area.");

    a_valid_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && is_valid_reg) |-> (area_reg != '0))
        else $error("Accepted triangle gives a zero area.");

    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && !$past(aresetn)) |-> !m_valid_reg)
        else $error("Result present right after reset.");

    a_load_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && ch_valid[ROOT_STAGES]) |=> m_valid_reg)
        else $error("Finished root lost at the output register.");
`endif

endmodule
